FILE: rtl/cevu_pkg.sv
// Package for the chemotaxis vertex update: constants, types and datapath functions.
package cevu_pkg;

   // Fixed-point format and pipeline shape.
   localparam int FRAC_BITS  = 24;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LAST_STAGE = DIV_STAGES + 4;
   localparam int NUM_STAGES = LAST_STAGE + 1;

   // Stage positions of the density path.
   localparam int ST_N_SHIFT  = 1;
   localparam int ST_N_MUL    = 2;
   localparam int ST_N_SAT    = 3;
   localparam int ST_GROW_MUL = 4;
   localparam int ST_GROW_SAT = 5;
   localparam int ST_RATE_N   = 6;
   localparam int ST_DT_N     = 7;

   // Stage positions of the concentration path, after the divider.
   localparam int ST_QC_MUL = DIV_STAGES + 1;
   localparam int ST_RATE_C = DIV_STAGES + 2;
   localparam int ST_DT_C   = DIV_STAGES + 3;
   localparam int ST_FINISH = DIV_STAGES + 4;

   typedef logic [30:0]        q31_type;
   typedef logic signed [31:0] s32_type;
   typedef logic signed [63:0] wide_type;

   localparam wide_type S32_MAX = 64'sd2147483647;
   localparam wide_type S32_MIN = -64'sd2147483648;
   localparam logic [31:0] ONE  = 32'(64'd1 << FRAC_BITS);

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_DIFFUSION = 3'd0,
      CSR_ALPHA     = 3'd1,
      CSR_GROWTH    = 3'd2,
      CSR_SOURCE    = 3'd3,
      CSR_CAPACITY  = 3'd4,
      CSR_TIME_STEP = 3'd5
   } csr_index_type;

   typedef struct packed {
      q31_type diffusion;
      q31_type alpha;
      q31_type growth;
      q31_type source;
      q31_type capacity;
      q31_type dt;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      diffusion: 31'd4194304,
      alpha:     31'd201661936,
      growth:    31'd25501368,
      source:    31'd16777216,
      capacity:  31'd16777216,
      dt:        31'd0
   };

   // Everything one vertex carries down the pipeline.
   typedef struct packed {
      q31_type                n;
      q31_type                c;
      s32_type                lap_c;
      s32_type                nmax_minus_n;
      logic                   last;
      wide_type               p_dx;
      wide_type               p_dy;
      wide_type               p_dz;
      wide_type               p_diff;
      wide_type               p_an;
      wide_type               p_sr;
      s32_type                dot;
      s32_type                t_diff;
      s32_type                an;
      s32_type                sr;
      wide_type               p_chem;
      wide_type               p_drift;
      wide_type               p_srn;
      s32_type                t_chem;
      s32_type                t_drift;
      s32_type                srn;
      wide_type               p_grow;
      s32_type                t_grow;
      s32_type                rate_n;
      wide_type               p_dtn;
      logic [31:0]            rem;
      logic [31:0]            dv;
      logic [FRAC_BITS-1:0]   q;
      wide_type               p_qc;
      s32_type                rate_c;
      wide_type               p_dtc;
      q31_type                n_next;
      q31_type                c_next;
      logic                   saturated;
   } pipe_type;

   // Exact 32 by 32 signed product.
   function automatic wide_type mul32(input s32_type a, input s32_type b);
      return wide_type'(a) * wide_type'(b);
   endfunction

   // Drop the fraction bits, rounding toward minus infinity.
   function automatic wide_type fshift(input wide_type v);
      return v >>> FRAC_BITS;
   endfunction

   // Clip to the signed 32-bit range.
   function automatic s32_type sat32(input wide_type v);
      if (v > S32_MAX) begin
         return S32_MAX[31:0];
      end
      if (v < S32_MIN) begin
         return S32_MIN[31:0];
      end
      return v[31:0];
   endfunction

   function automatic s32_type to_s32(input q31_type x);
      return s32_type'({1'b0, x});
   endfunction

   // Euler update of one value: bit 31 is the top flag, bits 30:0 the value.
   function automatic logic [31:0] finish(input q31_type old, input wide_type p);
      wide_type v;
      v = wide_type'({33'b0, old}) + fshift(p);
      if (v < 0) begin
         return 32'd0;
      end
      if (v > S32_MAX) begin
         return {1'b1, 31'h7FFF_FFFF};
      end
      return {1'b0, v[30:0]};
   endfunction

   // Work done by pipeline stage k on the item it receives.
   function automatic pipe_type stage_step(input int k, input cfg_type cfg, input pipe_type p);
      pipe_type    r;
      logic [32:0] shifted;
      logic [31:0] fn;
      logic [31:0] fc;
      int          step;
      r = p;

      // Restoring division of n << FRAC_BITS by one + n, two quotient bits a stage.
      if (k >= 1 && k <= DIV_STAGES) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            step = (k - 1) * DIV_STEPS + j;
            if (step < FRAC_BITS) begin
               shifted = {r.rem, 1'b0};
               if (shifted >= {1'b0, r.dv}) begin
                  r.rem = 32'(shifted - {1'b0, r.dv});
                  r.q   = {r.q[FRAC_BITS-2:0], 1'b1};
               end else begin
                  r.rem = shifted[31:0];
                  r.q   = {r.q[FRAC_BITS-2:0], 1'b0};
               end
            end
         end
      end

      // First products rescaled; the dot product sums before clipping.
      if (k == ST_N_SHIFT) begin
         r.dot    = sat32(fshift(p.p_dx) + fshift(p.p_dy) + fshift(p.p_dz));
         r.t_diff = sat32(fshift(p.p_diff));
         r.an     = sat32(fshift(p.p_an));
         r.sr     = sat32(fshift(p.p_sr));
      end

      if (k == ST_N_MUL) begin
         r.p_chem  = mul32(p.an, p.lap_c);
         r.p_drift = mul32(to_s32(cfg.alpha), p.dot);
         r.p_srn   = mul32(p.sr, to_s32(p.n));
      end

      if (k == ST_N_SAT) begin
         r.t_chem  = sat32(fshift(p.p_chem));
         r.t_drift = sat32(fshift(p.p_drift));
         r.srn     = sat32(fshift(p.p_srn));
      end

      if (k == ST_GROW_MUL) begin
         r.p_grow = mul32(p.srn, p.nmax_minus_n);
      end

      if (k == ST_GROW_SAT) begin
         r.t_grow = sat32(fshift(p.p_grow));
      end

      if (k == ST_RATE_N) begin
         r.rate_n = sat32(wide_type'(p.t_diff) - wide_type'(p.t_chem)
                          - wide_type'(p.t_drift) + wide_type'(p.t_grow));
      end

      if (k == ST_DT_N) begin
         r.p_dtn = mul32(to_s32(cfg.dt), p.rate_n);
      end

      // Chemical source term once the quotient is complete.
      if (k == ST_QC_MUL) begin
         r.p_qc = mul32(to_s32(cfg.source),
                        s32_type'({{(32 - FRAC_BITS){1'b0}}, p.q}) - to_s32(p.c));
      end

      if (k == ST_RATE_C) begin
         r.rate_c = sat32(wide_type'(p.lap_c) + wide_type'(sat32(fshift(p.p_qc))));
      end

      if (k == ST_DT_C) begin
         r.p_dtc = mul32(to_s32(cfg.dt), p.rate_c);
      end

      if (k == ST_FINISH) begin
         fn          = finish(p.n, p.p_dtn);
         fc          = finish(p.c, p.p_dtc);
         r.n_next    = fn[30:0];
         r.c_next    = fc[30:0];
         r.saturated = fn[31] | fc[31];
      end

      return r;
   endfunction

endpackage

FILE: rtl/chemotaxis_euler_vertex_update.sv
// Top level: pipelined explicit Euler step of the chemotaxis model for one vertex per request.
// The depth is set by the divider for n / (1 + n): 24 quotient bits, two per stage, 12 stages,
// plus the entry stage and four stages of source term, rate and update.
// Throughput: one request per cycle; a stall at the result port freezes every stage.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module chemotaxis_euler_vertex_update (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [30:0]           req_n_value,
   input  logic [30:0]           req_c_value,
   input  logic signed [31:0]    req_n_laplacian,
   input  logic signed [31:0]    req_c_laplacian,
   input  logic signed [31:0]    req_n_grad_x,
   input  logic signed [31:0]    req_n_grad_y,
   input  logic signed [31:0]    req_n_grad_z,
   input  logic signed [31:0]    req_c_grad_x,
   input  logic signed [31:0]    req_c_grad_y,
   input  logic signed [31:0]    req_c_grad_z,
   input  logic                  req_last_vertex,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [30:0]           rsp_n_next,
   output logic [30:0]           rsp_c_next,
   output logic                  rsp_saturated,
   output logic                  rsp_sweep_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [30:0]           csr_data
);

   cevu_pkg::cfg_type                    cfg_ff;
   cevu_pkg::cfg_type                    cfg_in;
   logic [cevu_pkg::NUM_STAGES-1:0]      valid_ff;
   logic [cevu_pkg::NUM_STAGES-1:0]      valid_in;
   cevu_pkg::pipe_type                   stage_ff [cevu_pkg::NUM_STAGES];
   cevu_pkg::pipe_type                   stage_in [cevu_pkg::NUM_STAGES];
   logic                                 advance;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cevu_pkg::CSR_DIFFUSION: cfg_in.diffusion = csr_data;
            cevu_pkg::CSR_ALPHA:     cfg_in.alpha     = csr_data;
            cevu_pkg::CSR_GROWTH:    cfg_in.growth    = csr_data;
            cevu_pkg::CSR_SOURCE:    cfg_in.source    = csr_data;
            cevu_pkg::CSR_CAPACITY:  cfg_in.capacity  = csr_data;
            cevu_pkg::CSR_TIME_STEP: cfg_in.dt        = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cevu_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The whole pipeline moves unless a finished result is held at the output.
   assign advance   = !valid_ff[cevu_pkg::LAST_STAGE] || rsp_ready;
   assign req_ready = advance;
   assign valid_in  = advance ? {valid_ff[cevu_pkg::NUM_STAGES-2:0], req_valid} : valid_ff;

   // Entry stage forms the first products and seeds the divider; later stages follow the package.
   always_comb begin
      stage_in[0]              = '0;
      stage_in[0].n            = req_n_value;
      stage_in[0].c            = req_c_value;
      stage_in[0].lap_c        = req_c_laplacian;
      stage_in[0].last         = req_last_vertex;
      stage_in[0].nmax_minus_n = cevu_pkg::to_s32(cfg_ff.capacity)
                                 - cevu_pkg::to_s32(req_n_value);
      stage_in[0].p_dx         = cevu_pkg::mul32(req_c_grad_x, req_n_grad_x);
      stage_in[0].p_dy         = cevu_pkg::mul32(req_c_grad_y, req_n_grad_y);
      stage_in[0].p_dz         = cevu_pkg::mul32(req_c_grad_z, req_n_grad_z);
      stage_in[0].p_diff       = cevu_pkg::mul32(cevu_pkg::to_s32(cfg_ff.diffusion),
                                                 req_n_laplacian);
      stage_in[0].p_an         = cevu_pkg::mul32(cevu_pkg::to_s32(cfg_ff.alpha),
                                                 cevu_pkg::to_s32(req_n_value));
      stage_in[0].p_sr         = cevu_pkg::mul32(cevu_pkg::to_s32(cfg_ff.source),
                                                 cevu_pkg::to_s32(cfg_ff.growth));
      stage_in[0].rem          = {1'b0, req_n_value};
      stage_in[0].dv           = cevu_pkg::ONE + {1'b0, req_n_value};
      for (int k = 1; k < cevu_pkg::NUM_STAGES; k++) begin
         stage_in[k] = cevu_pkg::stage_step(k, cfg_ff, stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   // The last stage is the output register.
   assign rsp_valid     = valid_ff[cevu_pkg::LAST_STAGE];
   assign rsp_n_next    = stage_ff[cevu_pkg::LAST_STAGE].n_next;
   assign rsp_c_next    = stage_ff[cevu_pkg::LAST_STAGE].c_next;
   assign rsp_saturated = stage_ff[cevu_pkg::LAST_STAGE].saturated;
   assign rsp_sweep_end = stage_ff[cevu_pkg::LAST_STAGE].last;

endmodule

FILE: rtl/cevu_checker.sv
// Port-level checks for the chemotaxis vertex update, bound to the top level.
module cevu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_n_next,
   input logic [30:0] rsp_c_next,
   input logic        rsp_saturated,
   input logic        rsp_sweep_end
);

   // The pipeline comes out of reset empty.
   a_empty_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Requests are taken exactly when the output register is free or draining.
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not match output state");

   // A stalled result keeps its payload.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_n_next) && $stable(rsp_c_next)
      && $stable(rsp_saturated) && $stable(rsp_sweep_end))
      else $error("stalled result changed");

   // The saturation flag only comes with a value at the top of range.
   a_saturated_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_n_next == 31'h7FFF_FFFF)
      || (rsp_c_next == 31'h7FFF_FFFF))
      else $error("saturated flag without a saturated value");

endmodule

bind chemotaxis_euler_vertex_update cevu_checker u_cevu_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench for the chemotaxis vertex update pipeline.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 1;
   localparam int RESET_CYCLES    = 8;
   localparam int PIPE_LATENCY    = 16;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 5;
   localparam int PHASE_VERTICES  = 216;
   localparam int QUIET_VERTICES  = 150;
   localparam int HOLD_AT_VERTEX  = 60;
   localparam int DIRECTED_ROWS   = 16;
   localparam int RESET_ROWS      = 4;
   localparam int DT_ONLY_ROWS    = 9;

   // Register indexes that the block does not decode.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   localparam cevu_pkg::q31_type QMAX  = 31'h7FFF_FFFF;
   localparam cevu_pkg::q31_type QONE  = 31'h0100_0000;
   localparam cevu_pkg::q31_type QHALF = 31'h0080_0000;
   localparam cevu_pkg::s32_type SMAX  = 32'sh7FFF_FFFF;
   localparam cevu_pkg::s32_type SMIN  = 32'sh8000_0000;
   localparam cevu_pkg::s32_type SONE  = 32'sh0100_0000;
   localparam cevu_pkg::s32_type SNEG  = 32'shFF00_0000;

   localparam cevu_pkg::cfg_type MODERATE_SETTINGS = '{
      diffusion: 31'h0040_0000,
      alpha:     31'h0100_0000,
      growth:    31'h0180_0000,
      source:    31'h0100_0000,
      capacity:  31'h0400_0000,
      dt:        31'h0010_0000
   };

   typedef struct packed {
      cevu_pkg::q31_type n_value;
      cevu_pkg::q31_type c_value;
      cevu_pkg::s32_type n_laplacian;
      cevu_pkg::s32_type c_laplacian;
      cevu_pkg::s32_type n_grad_x;
      cevu_pkg::s32_type n_grad_y;
      cevu_pkg::s32_type n_grad_z;
      cevu_pkg::s32_type c_grad_x;
      cevu_pkg::s32_type c_grad_y;
      cevu_pkg::s32_type c_grad_z;
      logic              last_vertex;
   } vertex_type;

   typedef struct packed {
      cevu_pkg::q31_type n_next;
      cevu_pkg::q31_type c_next;
      logic              saturated;
      logic              sweep_end;
   } update_type;

   typedef struct packed {
      logic       typed;
      update_type result;
      vertex_type vertex;
   } directed_row_type;

   // Extremes first; rows with a typed result are readable by eye.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Reset settings: a zero time step leaves both values untouched.
      '{1'b1, '{'0, '0, 1'b0, 1'b0}, '{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0}},
      '{1'b1, '{QMAX, QMAX, 1'b0, 1'b1},
        '{QMAX, QMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 1'b1}},
      '{1'b1, '{'0, '0, 1'b0, 1'b0},
        '{'0, '0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 1'b0}},
      '{1'b1, '{QONE, QHALF, 1'b0, 1'b1},
        '{QONE, QHALF, SONE, SNEG, SONE, SNEG, '0, SNEG, SONE, SMAX, 1'b1}},
      // Time step of one with the other registers at their defaults.
      '{1'b0, '0, '{QONE, '0, SONE, SNEG, SONE, SNEG, SONE, SNEG, SONE, SNEG, 1'b0}},
      '{1'b0, '0, '{QMAX, QMAX, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0}},
      '{1'b0, '0, '{'0, QMAX, SMAX, SMIN, '0, '0, '0, '0, '0, '0, 1'b1}},
      '{1'b0, '0, '{QHALF, QONE, '0, '0, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 1'b0}},
      '{1'b0, '0, '{31'd3, '0, '0, '0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 1'b1}},
      // Moderate settings on every register.
      '{1'b1, '{'0, '0, 1'b0, 1'b1}, '{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1}},
      '{1'b0, '0, '{QMAX, '0, '0, SMIN, '0, '0, '0, '0, '0, '0, 1'b0}},
      '{1'b0, '0,
        '{31'h0300_0000, QONE, SONE, SONE, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 1'b0}},
      '{1'b0, '0, '{31'd1, 31'd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, '0, 32'sd1, 32'sd1,
                    '0, 1'b0}},
      '{1'b0, '0,
        '{31'h0400_0000, 31'h0200_0000, SNEG, SONE, SONE, SONE, SNEG, SNEG, SONE, SONE,
          1'b1}},
      '{1'b0, '0, '{QMAX, QMAX, SMAX, SMAX, '0, '0, '0, '0, '0, '0, 1'b1}},
      '{1'b0, '0, '{'0, '0, '0, SNEG, '0, '0, '0, '0, '0, '0, 1'b0}}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   vertex_type        req_item;
   logic              rsp_valid;
   logic              rsp_ready;
   cevu_pkg::q31_type rsp_n_next;
   cevu_pkg::q31_type rsp_c_next;
   logic              rsp_saturated;
   logic              rsp_sweep_end;
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   cevu_pkg::q31_type csr_data;

   cevu_pkg::cfg_type model_cfg;
   update_type        pending_updates [$];
   int                errors = 0;
   int                updates_seen = 0;
   int                stalled_cycles = 0;
   bit                quiet_tail = 1'b0;
   bit                hold_request = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   chemotaxis_euler_vertex_update i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_n_value     (req_item.n_value),
      .req_c_value     (req_item.c_value),
      .req_n_laplacian (req_item.n_laplacian),
      .req_c_laplacian (req_item.c_laplacian),
      .req_n_grad_x    (req_item.n_grad_x),
      .req_n_grad_y    (req_item.n_grad_y),
      .req_n_grad_z    (req_item.n_grad_z),
      .req_c_grad_x    (req_item.c_grad_x),
      .req_c_grad_y    (req_item.c_grad_y),
      .req_c_grad_z    (req_item.c_grad_z),
      .req_last_vertex (req_item.last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_n_next      (rsp_n_next),
      .rsp_c_next      (rsp_c_next),
      .rsp_saturated   (rsp_saturated),
      .rsp_sweep_end   (rsp_sweep_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Drop the fraction bits, rounding toward minus infinity.
   function automatic longint frac_floor(input longint v);
      return v >>> cevu_pkg::FRAC_BITS;
   endfunction

   function automatic longint clip_s32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Euler update of one value: clamp at zero, saturate at the top with a flag.
   function automatic cevu_pkg::q31_type advance_value(input longint old, input longint dt,
                                                       input longint rate, inout logic top);
      longint v;
      v = old + frac_floor(dt * rate);
      if (v < 0) begin
         return '0;
      end
      if (v > 64'sd2147483647) begin
         top = 1'b1;
         return QMAX;
      end
      return cevu_pkg::q31_type'(v);
   endfunction

   // Expected new density and concentration of one vertex.
   function automatic update_type euler_step(input cevu_pkg::cfg_type cfg,
                                             input vertex_type v);
      longint          n, c, lap_n, lap_c, dot, t_diff, t_chem, t_drift, t_grow;
      longint          rate_n, rate_c, q, dt;
      longint unsigned numer, denom;
      logic            top;
      update_type      u;
      n     = longint'(v.n_value);
      c     = longint'(v.c_value);
      lap_n = longint'(v.n_laplacian);
      lap_c = longint'(v.c_laplacian);
      dt    = longint'(cfg.dt);
      top   = 1'b0;

      // Density rate: diffusion, chemotactic drift and logistic growth.
      dot = clip_s32(frac_floor(longint'(v.c_grad_x) * longint'(v.n_grad_x))
                     + frac_floor(longint'(v.c_grad_y) * longint'(v.n_grad_y))
                     + frac_floor(longint'(v.c_grad_z) * longint'(v.n_grad_z)));
      t_diff  = clip_s32(frac_floor(longint'(cfg.diffusion) * lap_n));
      t_chem  = clip_s32(frac_floor(clip_s32(frac_floor(longint'(cfg.alpha) * n)) * lap_c));
      t_drift = clip_s32(frac_floor(longint'(cfg.alpha) * dot));
      t_grow  = clip_s32(frac_floor(longint'(cfg.source) * longint'(cfg.growth)));
      t_grow  = clip_s32(frac_floor(t_grow * n));
      t_grow  = clip_s32(frac_floor(t_grow * (longint'(cfg.capacity) - n)));
      rate_n  = clip_s32(t_diff - t_chem - t_drift + t_grow);

      // Chemical rate with the saturating source n / (1 + n).
      numer  = longint'(n) << cevu_pkg::FRAC_BITS;
      denom  = (64'd1 << cevu_pkg::FRAC_BITS) + longint'(n);
      q      = longint'(numer / denom);
      rate_c = clip_s32(lap_c + clip_s32(frac_floor(longint'(cfg.source) * (q - c))));

      u.n_next    = advance_value(n, dt, rate_n, top);
      u.c_next    = advance_value(c, dt, rate_c, top);
      u.saturated = top;
      u.sweep_end = v.last_vertex;
      return u;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch in update %0d, %s: got %0d, expected %0d",
               updates_seen, field, got, want);
      errors++;
   endtask

   // Compare each delivered update with the oldest one pending.
   always @(posedge clock) begin : check_updates
      update_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("update with none pending", rsp_n_next, 0);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_n_next !== want.n_next) begin
               report_mismatch("n_next", rsp_n_next, want.n_next);
            end
            if (rsp_c_next !== want.c_next) begin
               report_mismatch("c_next", rsp_c_next, want.c_next);
            end
            if (rsp_saturated !== want.saturated) begin
               report_mismatch("saturated", rsp_saturated, want.saturated);
            end
            if (rsp_sweep_end !== want.sweep_end) begin
               report_mismatch("sweep_end", rsp_sweep_end, want.sweep_end);
            end
         end
         updates_seen++;
      end
   end

   // End the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Receiver: ready in random runs and stalls, plus one long hold-off on request.
   initial begin : update_sink
      int span;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) begin
         @(negedge clock);
      end
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 12);
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (span - 1) @(negedge clock);
         end else begin
            span = $urandom_range(1, 16);
            @(negedge clock);
            rsp_ready <= 1'b1;
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   function automatic cevu_pkg::q31_type pick_unsigned();
      case ($urandom_range(0, 5))
         0:       return QMAX;
         1:       return '0;
         2, 3:    return cevu_pkg::q31_type'($urandom_range(0, 4 << cevu_pkg::FRAC_BITS));
         default: return cevu_pkg::q31_type'($urandom);
      endcase
   endfunction

   function automatic cevu_pkg::s32_type pick_signed();
      case ($urandom_range(0, 6))
         0:       return SMAX;
         1:       return SMIN;
         2:       return '0;
         3, 4:    return cevu_pkg::s32_type'($urandom_range(0, 8 << cevu_pkg::FRAC_BITS))
                         - cevu_pkg::s32_type'(4 << cevu_pkg::FRAC_BITS);
         default: return cevu_pkg::s32_type'($urandom);
      endcase
   endfunction

   function automatic vertex_type make_vertex();
      vertex_type v;
      v.n_value     = pick_unsigned();
      v.c_value     = pick_unsigned();
      v.n_laplacian = pick_signed();
      v.c_laplacian = pick_signed();
      v.n_grad_x    = pick_signed();
      v.n_grad_y    = pick_signed();
      v.n_grad_z    = pick_signed();
      v.c_grad_x    = pick_signed();
      v.c_grad_y    = pick_signed();
      v.c_grad_z    = pick_signed();
      v.last_vertex = 1'b0;
      return v;
   endfunction

   // Register settings of each random phase: moderate, all high, all zero, random, mixed.
   function automatic cevu_pkg::cfg_type phase_settings(input int phase);
      cevu_pkg::cfg_type s;
      case (phase)
         0: s = MODERATE_SETTINGS;
         1: s = '{default: QMAX};
         2: s = '0;
         3: begin
            s.diffusion = cevu_pkg::q31_type'($urandom);
            s.alpha     = cevu_pkg::q31_type'($urandom);
            s.growth    = cevu_pkg::q31_type'($urandom);
            s.source    = cevu_pkg::q31_type'($urandom);
            s.capacity  = cevu_pkg::q31_type'($urandom);
            s.dt        = cevu_pkg::q31_type'($urandom);
         end
         default: begin
            s.diffusion = pick_unsigned();
            s.alpha     = pick_unsigned();
            s.growth    = pick_unsigned();
            s.source    = pick_unsigned();
            s.capacity  = pick_unsigned();
            s.dt        = cevu_pkg::q31_type'($urandom_range(0, QONE));
         end
      endcase
      return s;
   endfunction

   // Offer one vertex, optionally after an idle burst, and record its expected update.
   task automatic offer_vertex(input vertex_type v, input logic typed, input update_type want);
      if (!quiet_tail && !hold_request && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end
      @(negedge clock);
      req_item  <= v;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_updates.push_back(typed ? want : euler_step(model_cfg, v));
   endtask

   // Stop offering and let every pending update come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_setting(input logic [2:0] idx, input cevu_pkg::q31_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         cevu_pkg::CSR_DIFFUSION: model_cfg.diffusion = value;
         cevu_pkg::CSR_ALPHA:     model_cfg.alpha     = value;
         cevu_pkg::CSR_GROWTH:    model_cfg.growth    = value;
         cevu_pkg::CSR_SOURCE:    model_cfg.source    = value;
         cevu_pkg::CSR_CAPACITY:  model_cfg.capacity  = value;
         cevu_pkg::CSR_TIME_STEP: model_cfg.dt        = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load all registers; writes to undecoded indexes must change nothing.
   task automatic apply_settings(input cevu_pkg::cfg_type s);
      wait_drained();
      write_setting(cevu_pkg::CSR_DIFFUSION, s.diffusion);
      write_setting(cevu_pkg::CSR_ALPHA, s.alpha);
      write_setting(cevu_pkg::CSR_GROWTH, s.growth);
      write_setting(cevu_pkg::CSR_SOURCE, s.source);
      write_setting(cevu_pkg::CSR_CAPACITY, s.capacity);
      write_setting(cevu_pkg::CSR_TIME_STEP, s.dt);
      write_setting(CSR_SPARE_LO, cevu_pkg::q31_type'($urandom));
      write_setting(CSR_SPARE_HI, cevu_pkg::q31_type'($urandom));
   endtask

   // Random sweeps of vertices, the last one flagged, with some stray flags as noise.
   task automatic run_sweeps(input int count, input bit final_phase, input int hold_at);
      vertex_type v;
      int         sweep_left;
      sweep_left = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         v = make_vertex();
         sweep_left--;
         if ($urandom_range(0, 9) == 0) begin
            v.last_vertex = 1'($urandom_range(0, 1));
         end else begin
            v.last_vertex = (sweep_left == 0);
         end
         if (sweep_left == 0) begin
            sweep_left = $urandom_range(1, 40);
         end
         if (final_phase && i == count - QUIET_VERTICES) begin
            quiet_tail = 1'b1;
         end
         if (i == hold_at) begin
            hold_request = 1'b1;
         end
         offer_vertex(v, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = cevu_pkg::CSR_DIFFUSION;
      csr_data  = '0;
      model_cfg = '{
         diffusion: 31'd4194304,
         alpha:     31'd201661936,
         growth:    31'd25501368,
         source:    31'd16777216,
         capacity:  31'd16777216,
         dt:        31'd0
      };
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed rows: reset settings, then a unit time step, then moderate settings.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         if (row == RESET_ROWS) begin
            wait_drained();
            write_setting(cevu_pkg::CSR_TIME_STEP, QONE);
         end
         if (row == DT_ONLY_ROWS) begin
            apply_settings(MODERATE_SETTINGS);
         end
         offer_vertex(DIRECTED[row].vertex, DIRECTED[row].typed, DIRECTED[row].result);
      end

      // Random phases; the first one includes the long receiver hold-off.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(phase_settings(phase));
         run_sweeps(PHASE_VERTICES, phase == RANDOM_PHASES - 1,
                    phase == 0 ? HOLD_AT_VERTEX : -1);
      end

      wait_drained();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: chemotaxis_euler_vertex_update.f
rtl/cevu_pkg.sv
rtl/chemotaxis_euler_vertex_update.sv
rtl/cevu_checker.sv
dv/tb.sv
